// File: sv/fxalu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fxalu_pkg;

  localparam int FracBitsDefault = 8;

  typedef enum logic [3:0] {
    ACT_ADD  = 4'd0,
    ACT_SUB  = 4'd1,
    ACT_MUL  = 4'd2,
    ACT_DIV  = 4'd3,
    ACT_MIN  = 4'd4,
    ACT_MAX  = 4'd5,
    ACT_INC  = 4'd6,
    ACT_DEC  = 4'd7,
    ACT_TOI  = 4'd8,
    ACT_FROMI = 4'd9
  } action_t;

  typedef struct packed {
    logic [3:0]         action;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } alu_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               a_greater;
    logic               a_less;
    logic               a_equal;
    logic               fault_flag;
  } alu_out_t;

  typedef struct packed {
    logic        neg;
    logic        zero;
  } div_tag_t;

endpackage
`default_nettype wire

// File: sv/fxalu_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage, plus rounding.
// Computes floor((2n + d) / 2d) on magnitudes, i.e. n/d rounded half up.
module fxalu_div
  import fxalu_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDefault,
  localparam int NW = 33 + FRAC_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] num,
  input  wire logic [31:0]   den,
  output logic               out_valid,
  output logic [NW-1:0]      quo
);

  localparam int DW = 34;
  // Numerator 2n + d needs NW+1 bits; divisor is 2d.
  localparam int QW = NW + 1;

  // Entry i holds the output of stage i.
  logic [QW-1:0] q_s [QW];
  logic [DW-1:0] r_s [QW];
  logic [DW-1:0] d_s [QW];
  logic          v_s [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [QW-1:0] q_in;
    logic [DW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic          v_in;
    logic [DW:0]   trial;
    logic [DW-1:0] rsh;
    if (i == 0) begin : g_head
      assign q_in = {num, 1'b0} + QW'(den);
      assign r_in = '0;
      assign d_in = {1'b0, den, 1'b0};
      assign v_in = in_valid;
    end else begin : g_body
      assign q_in = q_s[i-1];
      assign r_in = r_s[i-1];
      assign d_in = d_s[i-1];
      assign v_in = v_s[i-1];
    end
    always_comb begin
      rsh   = {r_in[DW-2:0], q_in[QW-1]};
      trial = {1'b0, rsh} - {1'b0, d_in};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[i] <= 1'b0;
      end else begin
        v_s[i] <= v_in;
      end
      d_s[i] <= d_in;
      if (!trial[DW]) begin
        r_s[i] <= trial[DW-1:0];
        q_s[i] <= {q_in[QW-2:0], 1'b1};
      end else begin
        r_s[i] <= rsh;
        q_s[i] <= {q_in[QW-2:0], 1'b0};
      end
    end
  end

  assign out_valid = v_s[QW-1];
  assign quo       = q_s[QW-1][NW-1:0];

endmodule
`default_nettype wire

// File: sv/fixed_point_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Ports                  | Handshake
// ---------+------------------------+--------------------------------
// item in  | start, busy, in_item   | taken when start && !busy
// result   | done, out_item         | one cycle wide, no back-pressure
//
// One item may enter every cycle; busy is held low. Every result is registered
// through the stage 1 registers, the divider stages and a final output register,
// with the divider resolving one quotient bit per stage; all actions pass the
// same path length so results keep order.
// Reset is synchronous and clears only the valid bits of the stages.
module fixed_point_alu
  import fxalu_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire alu_in_t  in_item,
  output logic          done,
  output alu_out_t      out_item
);

  localparam int NW  = 33 + FRAC_BITS;
  localparam int LAT = NW + 2;
  localparam int PW  = 64;

  assign busy = 1'b0;

  // Stage 1: magnitudes, compares and simple actions.
  logic               s1_v;
  logic [3:0]         s1_act;
  logic               s1_gt, s1_lt, s1_eq, s1_neg, s1_bz;
  logic [31:0]        s1_ma, s1_mb;
  logic signed [33:0] s1_simple;
  logic [NW-1:0]      s1_num;

  logic signed [33:0] a_x, b_x;
  logic signed [33:0] simple;
  logic signed [63:0] fromi;
  always_comb begin
    a_x = 34'(in_item.operand_a);
    b_x = 34'(in_item.operand_b);
    fromi = 64'(in_item.operand_a) <<< FRAC_BITS;
    unique case (in_item.action)
      ACT_ADD:  simple = a_x + b_x;
      ACT_SUB:  simple = a_x - b_x;
      ACT_MIN:  simple = (a_x <= b_x) ? a_x : b_x;
      ACT_MAX:  simple = (a_x >= b_x) ? a_x : b_x;
      ACT_INC:  simple = a_x + 34'sd1;
      ACT_DEC:  simple = a_x - 34'sd1;
      ACT_TOI:  simple = a_x >>> FRAC_BITS;
      ACT_FROMI: begin
        if (fromi > 64'sd2147483647) simple = 34'sd2147483648;
        else if (fromi < -64'sd2147483648) simple = -34'sd2147483649;
        else simple = fromi[33:0];
      end
      default:  simple = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= start;
    end
    s1_act    <= in_item.action;
    s1_gt     <= in_item.operand_a > in_item.operand_b;
    s1_lt     <= in_item.operand_a < in_item.operand_b;
    s1_eq     <= in_item.operand_a == in_item.operand_b;
    s1_neg    <= in_item.operand_a[31] ^ in_item.operand_b[31];
    s1_bz     <= in_item.operand_b == '0;
    s1_ma     <= in_item.operand_a[31] ? 32'(-in_item.operand_a) : in_item.operand_a;
    s1_mb     <= in_item.operand_b[31] ? 32'(-in_item.operand_b) : in_item.operand_b;
    s1_simple <= simple;
  end
  assign s1_num = NW'(s1_ma) << FRAC_BITS;

  // Stage 2: magnitude product.
  logic [PW-1:0] s2_prod;
  always_ff @(posedge clk) begin
    s2_prod <= s1_ma * s1_mb;
  end

  // Divider runs in parallel from stage 1.
  logic          dv_v;
  logic [NW-1:0] dv_q;
  fxalu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s1_v),
    .num      (s1_num),
    .den      (s1_mb),
    .out_valid(dv_v),
    .quo      (dv_q)
  );

  // Stage 3: rounded product magnitude, then delay to meet the divider.
  logic [PW-1:0] s3_pm;
  always_ff @(posedge clk) begin
    s3_pm <= (s2_prod + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
  end

  // Side delay lines carrying everything but the divider's quotient.
  typedef struct packed {
    logic [3:0]         act;
    logic               gt, lt, eq, neg, bz;
    logic signed [33:0] simple;
  } side_t;

  side_t         side [LAT-1];
  logic [PW-1:0] pm_d [LAT-3];
  side_t         side_in;
  assign side_in = '{act: s1_act, gt: s1_gt, lt: s1_lt, eq: s1_eq,
                     neg: s1_neg, bz: s1_bz, simple: s1_simple};

  always_ff @(posedge clk) begin
    side[0] <= side_in;
    for (int i = 1; i < LAT - 1; i++) side[i] <= side[i-1];
    pm_d[0] <= s3_pm;
    for (int i = 1; i < LAT - 3; i++) pm_d[i] <= pm_d[i-1];
  end

  // Final stage: sign, saturation, selection.
  side_t         sf;
  logic [PW-1:0] mag;
  logic          big;
  logic signed [33:0] val;
  logic [31:0]   res;
  logic          flt;
  always_comb begin
    sf  = side[LAT-2];
    mag = (sf.act == ACT_MUL) ? pm_d[LAT-4] : PW'(dv_q);
    big = |mag[PW-1:32];
    if (sf.act == ACT_MUL || sf.act == ACT_DIV) begin
      if (big) val = sf.neg ? -34'sd2147483649 : 34'sd2147483648;
      else val = sf.neg ? -$signed({2'b00, mag[31:0]}) : $signed({2'b00, mag[31:0]});
    end else begin
      val = sf.simple;
    end
    flt = 1'b0;
    if (sf.act == ACT_DIV && sf.bz) begin
      res = '0;
      flt = 1'b1;
    end else if (val > 34'sd2147483647) begin
      res = 32'h7fffffff;
      flt = 1'b1;
    end else if (val < -34'sd2147483648) begin
      res = 32'h80000000;
      flt = 1'b1;
    end else begin
      res = val[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_v;
    end
    out_item <= '{result_value: res, a_greater: sf.gt, a_less: sf.lt,
                  a_equal: sf.eq, fault_flag: flt};
  end

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import fxalu_pkg::*;

  localparam int FRAC = 8;
  localparam int LATENCY = FRAC + 37;
  localparam longint CYCLE_LIMIT = 400000;

  class alu_scoreboard;
    alu_out_t pending[$];
    int errors;
    int items_seen;
    int results_seen;

    function new();
      errors = 0;
      items_seen = 0;
      results_seen = 0;
    endfunction

    // Rounded multiply and divide work on exact 64-bit products and magnitudes.
    function automatic alu_out_t compute(alu_in_t it);
      alu_out_t o;
      longint a;
      longint b;
      longint r;
      longint p;
      longint unsigned m;
      longint unsigned n;
      longint unsigned d;
      logic f;
      a = longint'(it.operand_a);
      b = longint'(it.operand_b);
      f = 1'b0;
      r = 0;
      case (it.action)
        ACT_ADD: r = a + b;
        ACT_SUB: r = a - b;
        ACT_MUL: begin
          p = a * b;
          m = (p < 0) ? longint'(0) - p : p;
          m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
          r = (p < 0) ? -longint'(m) : longint'(m);
        end
        ACT_DIV: begin
          if (b == 0) begin
            f = 1'b1;
          end else begin
            n = ((a < 0) ? -a : a) << FRAC;
            d = (b < 0) ? -b : b;
            m = (2 * n + d) / (2 * d);
            r = ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
          end
        end
        ACT_MIN: r = (a <= b) ? a : b;
        ACT_MAX: r = (a >= b) ? a : b;
        ACT_INC: r = a + 1;
        ACT_DEC: r = a - 1;
        ACT_TOI: r = a >>> FRAC;
        ACT_FROMI: r = a * (longint'(1) << FRAC);
        default: r = 0;
      endcase
      if (r > 64'sd2147483647) begin
        r = 64'sd2147483647;
        f = 1'b1;
      end else if (r < -64'sd2147483648) begin
        r = -64'sd2147483648;
        f = 1'b1;
      end
      o.result_value = r[31:0];
      o.a_greater = a > b;
      o.a_less = a < b;
      o.a_equal = a == b;
      o.fault_flag = f;
      return o;
    endfunction

    function void note_item(alu_in_t it);
      pending.push_back(compute(it));
      items_seen++;
    endfunction

    function void check_result(alu_out_t got);
      alu_out_t want;
      results_seen++;
      if (pending.size() == 0) begin
        $error("result with nothing outstanding: %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.result_value !== want.result_value) begin
        $error("result_value: expected %0d, got %0d", want.result_value, got.result_value);
        errors++;
      end
      if (got.a_greater !== want.a_greater) begin
        $error("a_greater: expected %b, got %b", want.a_greater, got.a_greater);
        errors++;
      end
      if (got.a_less !== want.a_less) begin
        $error("a_less: expected %b, got %b", want.a_less, got.a_less);
        errors++;
      end
      if (got.a_equal !== want.a_equal) begin
        $error("a_equal: expected %b, got %b", want.a_equal, got.a_equal);
        errors++;
      end
      if (got.fault_flag !== want.fault_flag) begin
        $error("fault_flag: expected %b, got %b", want.fault_flag, got.fault_flag);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  alu_in_t in_item;
  logic done;
  alu_out_t out_item;
  longint cycles;
  int gap_pct;
  alu_scoreboard board;

  fixed_point_alu #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .done(done),
    .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    board = new();
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) board.check_result(out_item);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Holds start for one item until it is taken, then idles at random.
  task automatic send_item(alu_in_t it);
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_item(it);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      in_item <= alu_in_t'({$urandom, $urandom, $urandom});
      @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h7fffffff - $urandom_range(3);
      1: return 32'h80000000 + $urandom_range(3);
      2: return $urandom_range(8) - 4;
      3: return $signed($urandom_range(65535)) - 32768;
      4: return $signed($urandom_range(4095)) <<< FRAC;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_action(action_t act, logic [31:0] a, logic [31:0] b);
    alu_in_t it;
    it.action = act;
    it.operand_a = a;
    it.operand_b = b;
    send_item(it);
  endtask

  initial begin
    alu_in_t it;
    rst = 1'b1;
    start = 1'b0;
    in_item = '0;
    gap_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extremes, saturation both ways, divide by zero, ties and unused codes.
    send_action(ACT_ADD, 32'h7fffffff, 32'h7fffffff);
    send_action(ACT_ADD, 32'h80000000, 32'h80000000);
    send_action(ACT_SUB, 32'h80000000, 32'h00000001);
    send_action(ACT_SUB, 32'h7fffffff, 32'hffffffff);
    send_action(ACT_MUL, 32'h7fffffff, 32'h7fffffff);
    send_action(ACT_MUL, 32'h80000000, 32'h7fffffff);
    send_action(ACT_MUL, 32'h00000180, 32'hffffff80);
    send_action(ACT_MUL, 32'h00000001, 32'h00000080);
    send_action(ACT_DIV, 32'h00001234, 32'h00000000);
    send_action(ACT_DIV, 32'h7fffffff, 32'h00000001);
    send_action(ACT_DIV, 32'h80000000, 32'hffffffff);
    send_action(ACT_DIV, 32'hfffffffd, 32'h00000200);
    send_action(ACT_MIN, 32'h00000005, 32'h00000005);
    send_action(ACT_MAX, 32'h80000000, 32'h7fffffff);
    send_action(ACT_INC, 32'h7fffffff, 32'h0);
    send_action(ACT_DEC, 32'h80000000, 32'h0);
    send_action(ACT_TOI, 32'hffffffff, 32'h0);
    send_action(ACT_TOI, 32'h80000000, 32'h7fffffff);
    send_action(ACT_FROMI, 32'h00800000, 32'h0);
    send_action(ACT_FROMI, 32'hff7fffff, 32'h0);
    it = '0;
    it.action = 4'hf;
    it.operand_a = 32'h1;
    send_item(it);
    it.action = 4'ha;
    send_item(it);

    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 22 : (phase == 1) ? 68 : 0;
      for (int k = 0; k < 230; k++) begin
        it.action = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10))
                                               : 4'($urandom_range(9));
        it.operand_a = pick_operand();
        it.operand_b = ($urandom_range(9) == 0) ? it.operand_a : pick_operand();
        send_item(it);
      end
    end
    start <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d items over all actions and unused codes, checked %0d results.",
             board.items_seen, board.results_seen);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// File: fixed_point_alu.f
sv/fxalu_pkg.sv
sv/fxalu_div.sv
sv/fixed_point_alu.sv
tb/tb.sv
